### rtl/mbc3_pkg.sv
// Package for the cartridge bank controller: bus access codes, register
// indexes, reset values and address decode constants.
// No dependencies.
`default_nettype none

package mbc3_pkg;

   typedef enum logic [1:0] {
      ACT_ROM_READ   = 2'd0,
      ACT_CTRL_WRITE = 2'd1,
      ACT_RAM_READ   = 2'd2,
      ACT_RAM_WRITE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_ROM_BANK_COUNT = 2'd0,
      CSR_RAM_BANK_COUNT = 2'd1,
      CSR_CLOCK_PRESENT  = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   localparam logic [7:0] ROM_BANK_COUNT_RST = 8'd128;
   localparam logic [2:0] RAM_BANK_COUNT_RST = 3'd4;
   localparam logic       CLOCK_PRESENT_RST  = 1'b1;

   localparam logic [6:0] ROM_BANK_RST      = 7'd1;
   localparam logic [7:0] RAM_SELECT_RST    = 8'd0;
   localparam logic [3:0] RAM_ENABLE_KEY    = 4'hA;
   localparam logic [2:0] RAM_BANK_MAX      = 3'd4;
   localparam logic [7:0] CLOCK_SELECT_LO   = 8'h08;
   localparam logic [7:0] CLOCK_SELECT_HI   = 8'h0C;
   localparam logic [7:0] RAM_SELECT_HI     = 8'h03;
   localparam logic [7:0] OPEN_BUS_BYTE     = 8'hFF;
   localparam int         CLOCK_BYTE_COUNT  = 5;
   localparam int         RAM_BANK_BYTES    = 8192;
   localparam int         ROM_ADDR_W        = 21;

   // Start of the external RAM window on the CPU bus.
   localparam logic signed [17:0] RAM_WINDOW_BASE = 18'sh0A000;

endpackage

`default_nettype wire

### rtl/mbc3_intf.sv
// Valid/ready channel interfaces for bus accesses, results and register
// writes of the bank controller. Depends on mbc3_pkg.
`default_nettype none

interface mbc3_req_if;
   import mbc3_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] address;
   logic [7:0]  write_data;

   modport source (output valid, action, address, write_data, input ready);
   modport sink (input valid, action, address, write_data, output ready);
endinterface

interface mbc3_rsp_if;
   import mbc3_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [7:0]            read_data;
   logic                  rom_fetch;
   logic [ROM_ADDR_W-1:0] rom_address;

   modport source (output valid, read_data, rom_fetch, rom_address, input ready);
   modport sink (input valid, read_data, rom_fetch, rom_address, output ready);
endinterface

interface mbc3_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/mbc3_ram.sv
// Cartridge RAM store: single-port synchronous byte memory with registered
// read data and a zero-fill sweep after reset. No package dependencies.
`default_nettype none

module mbc3_ram #(
   parameter int RAM_BYTES = 32768
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(RAM_BYTES)-1:0] addr,
   input  wire logic [7:0]                   wr_data,
   output logic      [7:0]                   rd_data,
   output logic                              busy
);

   localparam int RAM_AW = $clog2(RAM_BYTES);
   localparam logic [RAM_AW-1:0] LAST_ADDR = RAM_AW'(RAM_BYTES - 1);

   logic [7:0]        mem_ff [RAM_BYTES];
   logic [7:0]        rd_data_ff;
   logic [RAM_AW-1:0] clr_addr_ff;
   logic [RAM_AW-1:0] clr_addr_in;
   logic              busy_ff;
   logic              busy_in;
   logic              mem_we;
   logic [RAM_AW-1:0] mem_wa;
   logic [7:0]        mem_wd;

   // The fill sweep owns the write port until every entry holds zero.
   always_comb begin
      clr_addr_in = clr_addr_ff;
      busy_in     = busy_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + RAM_AW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      mem_we = busy_ff | wr_en;
      mem_wa = busy_ff ? clr_addr_ff : addr;
      mem_wd = busy_ff ? 8'd0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

`default_nettype wire

### rtl/mbc3_bank_controller_with_clock_regs.sv
// Cartridge bank controller with clock byte registers, top level.
// Results: a ROM read or RAM read passes result stage s1, then the output register.
// Throughput: one access per cycle, set by the single RAM port, unless results back up.
// Reset: synchronous; afterwards a zero-fill sweep clears every RAM byte
// and no access is taken until it ends (register writes are taken throughout).
// Depends on mbc3_pkg, mbc3_intf and mbc3_ram.
`default_nettype none

module mbc3_bank_controller_with_clock_regs #(
   parameter int RAM_BYTES = 32768
) (
   input  wire logic clock,
   input  wire logic reset,
   mbc3_req_if.sink  req_ch,
   mbc3_rsp_if.source rsp_ch,
   mbc3_csr_if.sink  csr_ch
);

   import mbc3_pkg::*;

   localparam int RAM_AW = $clog2(RAM_BYTES);
   // Number of 8 KiB banks this build actually stores.
   localparam logic [2:0] RAM_BANK_LIMIT = 3'(RAM_BYTES / RAM_BANK_BYTES);

   // ---------------------------------------------------------------------
   // Configuration registers. The write channel is always ready; an index
   // past the last register is dropped.
   // ---------------------------------------------------------------------
   logic [7:0] rom_bank_count_ff;
   logic [2:0] ram_bank_count_ff;
   logic       clock_present_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_count_ff <= ROM_BANK_COUNT_RST;
         ram_bank_count_ff <= RAM_BANK_COUNT_RST;
         clock_present_ff  <= CLOCK_PRESENT_RST;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_ROM_BANK_COUNT: rom_bank_count_ff <= csr_ch.data;
            CSR_RAM_BANK_COUNT: ram_bank_count_ff <= csr_ch.data[2:0];
            CSR_CLOCK_PRESENT:  clock_present_ff  <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   // ---------------------------------------------------------------------
   // Handshake. One result stage (s1) sits behind the RAM read, and an
   // output register decouples the result channel from the input.
   // ---------------------------------------------------------------------
   logic       ram_busy;
   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;
   logic       req_ready;
   logic       accept;
   action_type act;

   assign act       = action_type'(req_ch.action);
   assign out_free  = ~rsp_valid_ff | rsp_ch.ready;
   assign req_ready = ~ram_busy & (~s1_valid_ff | out_free);
   assign accept    = req_ch.valid & req_ready;
   assign req_ch.ready = req_ready;

   // ---------------------------------------------------------------------
   // Bank state written by control writes and clock byte registers.
   // ---------------------------------------------------------------------
   logic       ram_enable_ff;
   logic [6:0] rom_bank_ff;
   logic [7:0] ram_select_ff;
   logic [7:0] clock_byte_ff [CLOCK_BYTE_COUNT];

   // ---------------------------------------------------------------------
   // Decode of the access against the current bank state.
   // ---------------------------------------------------------------------
   logic [ROM_ADDR_W-1:0] rom_off;
   logic                  rom_ok;
   logic signed [17:0]    ram_off;
   logic [2:0]            ram_banks;
   logic                  ram_sel;
   logic                  ram_ok;
   logic                  clock_sel;
   logic [2:0]            clock_idx;
   logic                  ram_rd_en;
   logic                  ram_wr_en;
   logic                  clock_wr_en;
   logic [7:0]            ram_rd_data;

   always_comb begin
      // The switchable window at 0x4000 maps onto the selected bank.
      if (req_ch.address[14]) begin
         rom_off = {rom_bank_ff, req_ch.address[13:0]};
      end else begin
         rom_off = {7'd0, req_ch.address[13:0]};
      end
      rom_ok = ~req_ch.address[15] & ({1'b0, rom_off[20:14]} < rom_bank_count_ff);

      // Banks present: the programmed count, capped at four and at what is built.
      ram_banks = (ram_bank_count_ff > RAM_BANK_MAX) ? RAM_BANK_MAX : ram_bank_count_ff;
      if (ram_banks > RAM_BANK_LIMIT) begin
         ram_banks = RAM_BANK_LIMIT;
      end

      // Signed offset into the store; it is in range when it is not negative
      // and its 8 KiB bank number lies below the banks present.
      ram_off = $signed({3'b000, ram_select_ff[1:0], 13'd0})
              + $signed({2'b00, req_ch.address}) - RAM_WINDOW_BASE;
      ram_sel = ram_enable_ff & (ram_select_ff <= RAM_SELECT_HI);
      ram_ok  = ram_sel & ~ram_off[17] & (ram_off[16:13] < {1'b0, ram_banks});

      clock_sel = ram_enable_ff & clock_present_ff
                & (ram_select_ff >= CLOCK_SELECT_LO) & (ram_select_ff <= CLOCK_SELECT_HI);
      // Selects 0x08 to 0x0C land on clock bytes 0 to 4.
      clock_idx = ram_select_ff[2:0];

      ram_rd_en   = accept & (act == ACT_RAM_READ) & ram_ok;
      ram_wr_en   = accept & (act == ACT_RAM_WRITE) & ram_ok;
      clock_wr_en = accept & (act == ACT_RAM_WRITE) & clock_sel & ~ram_sel;
   end

   mbc3_ram #(
      .RAM_BYTES (RAM_BYTES)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_off[RAM_AW-1:0]),
      .wr_data (req_ch.write_data),
      .rd_data (ram_rd_data),
      .busy    (ram_busy)
   );

   // ---------------------------------------------------------------------
   // Control writes take effect at their transfer, so the very next access
   // already sees the new bank state.
   // ---------------------------------------------------------------------
   logic       ram_enable_in;
   logic [6:0] rom_bank_in;
   logic [7:0] ram_select_in;

   always_comb begin
      ram_enable_in = ram_enable_ff;
      rom_bank_in   = rom_bank_ff;
      ram_select_in = ram_select_ff;
      if (accept && act == ACT_CTRL_WRITE) begin
         case (req_ch.address[15:13])
            3'd0: ram_enable_in = (req_ch.write_data[3:0] == RAM_ENABLE_KEY);
            3'd1: begin
               rom_bank_in = req_ch.write_data[6:0];
               if (req_ch.write_data[6:0] == 7'd0) begin
                  rom_bank_in = ROM_BANK_RST;
               end
            end
            3'd2: ram_select_in = req_ch.write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_enable_ff <= 1'b0;
         rom_bank_ff   <= ROM_BANK_RST;
         ram_select_ff <= RAM_SELECT_RST;
         for (int i = 0; i < CLOCK_BYTE_COUNT; i++) begin
            clock_byte_ff[i] <= 8'd0;
         end
      end else begin
         ram_enable_ff <= ram_enable_in;
         rom_bank_ff   <= rom_bank_in;
         ram_select_ff <= ram_select_in;
         if (clock_wr_en) begin
            clock_byte_ff[clock_idx] <= req_ch.write_data;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result stage s1: everything but the RAM byte is settled at transfer;
   // the RAM byte comes from the memory's read register, loaded at that transfer.
   // ---------------------------------------------------------------------
   logic                  s1_use_mem_ff;
   logic [7:0]            s1_data_ff;
   logic                  s1_rom_fetch_ff;
   logic [ROM_ADDR_W-1:0] s1_rom_addr_ff;
   logic                  gives_result;

   assign gives_result = (act == ACT_ROM_READ) | (act == ACT_RAM_READ);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = gives_result;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_use_mem_ff   <= 1'b0;
         s1_rom_fetch_ff <= 1'b0;
         s1_rom_addr_ff  <= '0;
         s1_data_ff      <= OPEN_BUS_BYTE;
         if (act == ACT_ROM_READ) begin
            if (rom_ok) begin
               s1_rom_fetch_ff <= 1'b1;
               s1_rom_addr_ff  <= rom_off;
               s1_data_ff      <= 8'd0;
            end
         end else if (ram_ok) begin
            s1_use_mem_ff <= 1'b1;
         end else if (clock_sel && !ram_sel) begin
            s1_data_ff <= clock_byte_ff[clock_idx];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output register.
   // ---------------------------------------------------------------------
   logic [7:0]            rsp_data_ff;
   logic                  rsp_rom_fetch_ff;
   logic [ROM_ADDR_W-1:0] rsp_rom_addr_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_data_ff      <= s1_use_mem_ff ? ram_rd_data : s1_data_ff;
         rsp_rom_fetch_ff <= s1_rom_fetch_ff;
         rsp_rom_addr_ff  <= s1_rom_addr_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_data   = rsp_data_ff;
   assign rsp_ch.rom_fetch   = rsp_rom_fetch_ff;
   assign rsp_ch.rom_address = rsp_rom_addr_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   a_no_access_while_filling: assert property (@(posedge clock) disable iff (reset)
      accept |-> !ram_busy)
      else $error("access transferred during RAM fill sweep");

   a_read_reaches_stage: assert property (@(posedge clock) disable iff (reset)
      (accept && act == ACT_RAM_READ) |=> s1_valid_ff)
      else $error("RAM read transfer did not enter the result stage");

   a_ctrl_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && act == ACT_CTRL_WRITE) |=> !s1_valid_ff)
      else $error("control write produced a result");

   a_rom_fetch_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rom_fetch_ff) |-> (rsp_data_ff == 8'd0))
      else $error("ROM fetch result carries nonzero read data");

   a_rom_bank_nonzero: assert property (@(posedge clock) disable iff (reset)
      $past(accept && act == ACT_CTRL_WRITE) |-> (rom_bank_ff != 7'd0))
      else $error("ROM bank select became zero");

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for mbc3_bank_controller_with_clock_regs: a scripted and a random bus
// access stream, with every read result checked against a predictor kept in this file.
// Depends on mbc3_pkg, the channel interfaces of mbc3_intf and the controller RTL.

module tb;
   import mbc3_pkg::*;

   // Sizes of the cartridge as this bench builds it.
   localparam int RAM_STORE_BYTES = 32768;
   localparam int ROM_BANK_BYTES  = 16384;

   // Bus decode boundaries for ROM reads and the start of the RAM window.
   localparam logic [15:0] ROM_BANKED_BASE = 16'h4000;
   localparam logic [15:0] ROM_WINDOW_END  = 16'h8000;
   localparam logic [15:0] RAM_WINDOW_ADDR = 16'hA000;

   // Bus timing allowances. Reads come back through result stage s1 and the output
   // register; the settle wait lets writes that are still in flight retire.
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 150000;
   localparam int PAUSE_PERCENT  = 29;
   localparam int REPORT_LIMIT   = 10;

   localparam int FIRST_BURST = 70;
   localparam int PHASE_ITEMS = 86;
   localparam int PHASES      = 7;
   localparam int SCRIPT_LEN  = 27;

   // Control writes are decoded on the top three address bits.
   typedef enum logic [2:0] {
      CTRL_RAM_ENABLE  = 3'd0,
      CTRL_ROM_BANK    = 3'd1,
      CTRL_RAM_SELECT  = 3'd2,
      CTRL_CLOCK_LATCH = 3'd3
   } ctrl_region_type;

   typedef struct packed {
      action_type  action;
      logic [15:0] address;
      logic [7:0]  write_data;
   } bus_access_type;

   typedef struct packed {
      logic [7:0]            read_data;
      logic                  rom_fetch;
      logic [ROM_ADDR_W-1:0] rom_address;
   } bus_result_type;

   // One scripted access. When typed is set, the want_ fields hold the result as it
   // can be read straight off the decode rules; otherwise the predictor supplies it.
   typedef struct packed {
      action_type            action;
      logic [15:0]           address;
      logic [7:0]            write_data;
      logic                  typed;
      logic [7:0]            want_data;
      logic                  want_fetch;
      logic [ROM_ADDR_W-1:0] want_address;
   } script_row_type;

   // The scripted opening runs under the reset register values: 128 ROM banks, four RAM
   // banks and a clock. It touches the fixed and switched ROM halves and the space
   // beyond them, access while RAM is off, a zero bank write turning into bank one,
   // the highest bank, the last byte of the last RAM bank and the first byte past it,
   // the first and the last clock byte, a select that reaches nothing, the latch and
   // switching RAM off again.
   script_row_type script [SCRIPT_LEN] = '{
      '{ACT_ROM_READ,   16'h0000, 8'h00, 1'b1, 8'h00, 1'b1, 21'h000000},
      '{ACT_ROM_READ,   16'h7FFF, 8'h00, 1'b1, 8'h00, 1'b1, 21'h007FFF},
      '{ACT_ROM_READ,   16'h8000, 8'h00, 1'b1, 8'hFF, 1'b0, 21'h000000},
      '{ACT_RAM_READ,   16'hA000, 8'h00, 1'b1, 8'hFF, 1'b0, 21'h000000},
      '{ACT_RAM_WRITE,  16'hA000, 8'h55, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_CTRL_WRITE, 16'h1FFF, 8'hFA, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_RAM_READ,   16'hA000, 8'h00, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_CTRL_WRITE, 16'h2000, 8'h00, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_ROM_READ,   16'h4000, 8'h00, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_CTRL_WRITE, 16'h3FFF, 8'hFF, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_ROM_READ,   16'h7FFF, 8'h00, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_ROM_READ,   16'hFFFF, 8'h00, 1'b1, 8'hFF, 1'b0, 21'h000000},
      '{ACT_CTRL_WRITE, 16'h4000, 8'h03, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_RAM_WRITE,  16'hBFFF, 8'hA5, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_RAM_READ,   16'hBFFF, 8'h00, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_RAM_READ,   16'hC000, 8'h00, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_CTRL_WRITE, 16'h5FFF, 8'h08, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_RAM_WRITE,  16'h0000, 8'h3C, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_RAM_READ,   16'hFFFF, 8'h00, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_CTRL_WRITE, 16'h4000, 8'h0C, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_RAM_WRITE,  16'hA000, 8'hC3, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_RAM_READ,   16'hA000, 8'h00, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_CTRL_WRITE, 16'h4000, 8'hFF, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_RAM_READ,   16'hA000, 8'h00, 1'b1, 8'hFF, 1'b0, 21'h000000},
      '{ACT_CTRL_WRITE, 16'h6000, 8'h01, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_CTRL_WRITE, 16'h0000, 8'h00, 1'b0, 8'h00, 1'b0, 21'h000000},
      '{ACT_RAM_READ,   16'hA000, 8'h00, 1'b1, 8'hFF, 1'b0, 21'h000000}
   };

   // Register settings of the random phases, extremes included. Register data is
   // eight bits wide, so some entries also check that only the low bits count.
   // The sixth phase draws its values at random.
   logic [7:0] phase_rom_banks [PHASES] = '{8'd2, 8'd255, 8'd0, 8'd1, 8'd128, 8'd0, 8'd64};
   logic [7:0] phase_ram_banks [PHASES] = '{8'h01, 8'h07, 8'hF8, 8'h02, 8'h04, 8'h00, 8'h03};
   logic [7:0] phase_clock     [PHASES] = '{8'h00, 8'h01, 8'hFE, 8'h01, 8'h01, 8'h00, 8'hFF};

   logic clock;
   logic reset;

   mbc3_req_if req_if ();
   mbc3_rsp_if rsp_if ();
   mbc3_csr_if csr_if ();

   mbc3_bank_controller_with_clock_regs #(
      .RAM_BYTES(RAM_STORE_BYTES)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source),
      .csr_ch (csr_if.sink)
   );

   // Predicted cartridge state: register copies and the mapper's own state.
   logic [7:0] rom_bank_total;
   logic [2:0] ram_bank_total;
   logic       clock_fitted;
   logic       ram_on;
   logic [6:0] rom_bank;
   logic [7:0] ram_select;
   logic [7:0] clock_bytes [CLOCK_BYTE_COUNT];
   logic [7:0] ram_image [RAM_STORE_BYTES];

   // Read results still owed by the controller, oldest first.
   bus_result_type owed_reads [$];

   int mismatch_count;
   int hold_requests;  // bumped by the stimulus, served by the result side
   bit steady;         // set for a stretch in which neither side idles

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit take_pause();
      return !steady && ($urandom_range(0, 99) < PAUSE_PERCENT);
   endfunction

   // Applies one bus access to the predicted state and tells what it returns.
   function automatic void predict_access(input bus_access_type acc, output bit answers,
                                          output bus_result_type res);
      int rom_offset;
      int rom_span;
      int ram_offset;
      int ram_banks;
      bit in_range;
      res = '{read_data: OPEN_BUS_BYTE, rom_fetch: 1'b0, rom_address: '0};
      answers = 1'b0;
      case (acc.action)
         ACT_ROM_READ: begin
            answers = 1'b1;
            in_range = 1'b1;
            rom_offset = 0;
            rom_span = int'(rom_bank_total) * ROM_BANK_BYTES;
            if (acc.address < ROM_BANKED_BASE) begin
               rom_offset = int'(acc.address);
            end else if (acc.address < ROM_WINDOW_END) begin
               rom_offset = int'(rom_bank) * ROM_BANK_BYTES + int'(acc.address)
                          - int'(ROM_BANKED_BASE);
            end else begin
               in_range = 1'b0;
            end
            if (in_range && rom_offset < rom_span) begin
               res = '{read_data: 8'h00, rom_fetch: 1'b1,
                       rom_address: rom_offset[ROM_ADDR_W-1:0]};
            end
         end
         ACT_CTRL_WRITE: begin
            case (acc.address[15:13])
               CTRL_RAM_ENABLE: ram_on = (acc.write_data[3:0] == RAM_ENABLE_KEY);
               CTRL_ROM_BANK: begin
                  rom_bank = acc.write_data[6:0];
                  if (rom_bank == '0) rom_bank = ROM_BANK_RST;
               end
               CTRL_RAM_SELECT: ram_select = acc.write_data;
               default: ;  // latch and anything above has no effect
            endcase
         end
         default: begin
            // RAM read or RAM write: a RAM bank through the signed window offset,
            // or one of the clock bytes.
            answers = (acc.action == ACT_RAM_READ);
            if (ram_on && ram_select <= RAM_SELECT_HI) begin
               ram_banks = (ram_bank_total > RAM_BANK_MAX) ? int'(RAM_BANK_MAX)
                                                         : int'(ram_bank_total);
               if (ram_banks > RAM_STORE_BYTES / RAM_BANK_BYTES)
                  ram_banks = RAM_STORE_BYTES / RAM_BANK_BYTES;
               ram_offset = int'(ram_select) * RAM_BANK_BYTES + int'(acc.address)
                          - int'(RAM_WINDOW_BASE);
               if (ram_offset >= 0 && ram_offset < ram_banks * RAM_BANK_BYTES) begin
                  if (answers) res.read_data = ram_image[ram_offset];
                  else ram_image[ram_offset] = acc.write_data;
               end
            end else if (ram_on && clock_fitted && ram_select >= CLOCK_SELECT_LO
                         && ram_select <= CLOCK_SELECT_HI) begin
               if (answers) res.read_data = clock_bytes[ram_select - CLOCK_SELECT_LO];
               else clock_bytes[ram_select - CLOCK_SELECT_LO] = acc.write_data;
            end
         end
      endcase
   endfunction

   // Random access mix. Most control writes hit the three live registers with
   // values that keep RAM on and point at RAM banks or clock bytes, and most RAM
   // traffic lands on a small hot spot so that reads find earlier writes. The rest
   // spreads over the whole bus.
   function automatic bus_access_type random_access();
      bus_access_type acc;
      int unsigned pick;
      int unsigned shade;
      pick = $urandom_range(0, 99);
      shade = $urandom_range(0, 9);
      acc.address = 16'($urandom);
      acc.write_data = 8'($urandom);
      if (pick < 22) begin
         acc.action = ACT_CTRL_WRITE;
         if (shade < 8) acc.address[15:13] = 3'($urandom_range(0, 2));
         shade = $urandom_range(0, 9);
         case (acc.address[15:13])
            CTRL_RAM_ENABLE: if (shade < 7) acc.write_data[3:0] = RAM_ENABLE_KEY;
            CTRL_ROM_BANK:   if (shade == 0) acc.write_data[6:0] = '0;
            CTRL_RAM_SELECT: begin
               if (shade < 5) acc.write_data = 8'($urandom_range(0, RAM_SELECT_HI));
               else if (shade < 8)
                  acc.write_data = 8'($urandom_range(CLOCK_SELECT_LO, CLOCK_SELECT_HI));
            end
            default: ;
         endcase
      end else if (pick < 45) begin
         acc.action = ACT_ROM_READ;
         if (shade < 8) acc.address[15] = 1'b0;
      end else begin
         acc.action = (pick < 70) ? ACT_RAM_READ : ACT_RAM_WRITE;
         if (shade < 6) acc.address = RAM_WINDOW_ADDR + 16'($urandom_range(0, 31));
         else if (shade < 9) acc.address[15:13] = 3'b101;
      end
      return acc;
   endfunction

   // Offers one access, with random idle cycles first, and records what it owes
   // once the transfer has happened. Valid stays high afterwards so that back to
   // back transfers are possible; the next call or a drain lowers it.
   task automatic issue_access(input bus_access_type acc, input bit typed,
                               input bus_result_type typed_want);
      bit answers;
      bus_result_type want;
      while (take_pause()) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.action     <= acc.action;
      req_if.address    <= acc.address;
      req_if.write_data <= acc.write_data;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_access(acc, answers, want);
      if (answers) owed_reads.push_back(typed ? typed_want : want);
   endtask

   // Sends one register write; the caller lowers valid after its last write.
   task automatic write_reg(input csr_index_type idx, input logic [7:0] value);
      while (take_pause()) begin
         csr_if.valid <= 1'b0;
         @(posedge clock);
      end
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         CSR_ROM_BANK_COUNT: rom_bank_total = value;
         CSR_RAM_BANK_COUNT: ram_bank_total = value[2:0];
         CSR_CLOCK_PRESENT:  clock_fitted   = value[0];
         default: ;
      endcase
   endtask

   // Stops offering accesses and waits until every read has come back, then lets
   // any write still in the pipeline retire. The watchdog bounds the wait.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (owed_reads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_burst(input int count);
      bus_result_type none;
      none = '0;
      for (int n = 0; n < count; n++) issue_access(random_access(), 1'b0, none);
   endtask

   // Result side: checks each read transfer against the oldest owed result, then
   // decides ready for the next cycle. A hold request keeps ready low for a long
   // stretch so that the controller fills up and pushes back on its input.
   initial begin : result_side
      bus_result_type want;
      int hold_left;
      int hold_served;
      int result_index;
      hold_left = 0;
      hold_served = 0;
      result_index = 0;
      mismatch_count = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (owed_reads.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: result %0d not owed: data %02h fetch %0b addr %06h",
                           $time, result_index, rsp_if.read_data, rsp_if.rom_fetch,
                           rsp_if.rom_address);
            end else begin
               want = owed_reads.pop_front();
               if (rsp_if.read_data !== want.read_data || rsp_if.rom_fetch !== want.rom_fetch
                   || rsp_if.rom_address !== want.rom_address) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("%0t: result %0d expected %02h %0b %06h, got %02h %0b %06h",
                              $time, result_index, want.read_data, want.rom_fetch,
                              want.rom_address, rsp_if.read_data, rsp_if.rom_fetch,
                              rsp_if.rom_address);
               end
            end
            result_index++;
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !take_pause();
         end
      end
   end

   // Ends the run when no transfer of any kind has happened for too long. The
   // limit covers the RAM clearing sweep after reset, during which no access is taken.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
             || (csr_if.valid && csr_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("mbc3_bank_controller_with_clock_regs regression: fail");
      $finish;
   end

   // Stimulus: reset, the scripted opening under reset register values, then phases
   // of random accesses, each under its own register setting written while idle.
   initial begin : stimulus
      bus_access_type acc;
      bus_result_type want;
      logic [7:0] rom_value;
      logic [7:0] ram_value;
      logic [7:0] clock_value;

      // Known values on every input from time zero.
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.action     <= ACT_ROM_READ;
      req_if.address    <= '0;
      req_if.write_data <= '0;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= CSR_ROM_BANK_COUNT;
      csr_if.data       <= '0;
      hold_requests = 0;
      steady = 1'b0;

      rom_bank_total = ROM_BANK_COUNT_RST;
      ram_bank_total = RAM_BANK_COUNT_RST;
      clock_fitted   = CLOCK_PRESENT_RST;
      ram_on         = 1'b0;
      rom_bank       = ROM_BANK_RST;
      ram_select     = RAM_SELECT_RST;
      foreach (clock_bytes[i]) clock_bytes[i] = '0;
      foreach (ram_image[i]) ram_image[i] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The first access waits out the RAM clearing sweep.
      foreach (script[i]) begin
         acc = '{action: script[i].action, address: script[i].address,
                 write_data: script[i].write_data};
         want = '{read_data: script[i].want_data, rom_fetch: script[i].want_fetch,
                  rom_address: script[i].want_address};
         issue_access(acc, script[i].typed, want);
      end
      random_burst(FIRST_BURST);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         rom_value   = phase_rom_banks[p];
         ram_value   = phase_ram_banks[p];
         clock_value = phase_clock[p];
         if (p == 5) begin
            rom_value   = 8'($urandom);
            ram_value   = 8'($urandom);
            clock_value = 8'($urandom);
         end
         write_reg(CSR_ROM_BANK_COUNT, rom_value);
         write_reg(CSR_RAM_BANK_COUNT, ram_value);
         write_reg(CSR_CLOCK_PRESENT, clock_value);
         // The spare index must leave every register alone.
         if (p == 2) write_reg(CSR_UNUSED, 8'hFF);
         csr_if.valid <= 1'b0;
         @(posedge clock);

         // One phase runs without idle cycles on either side.
         steady = (p == 4);
         // In another the result side stalls for a long time while accesses keep coming.
         if (p == 1) hold_requests++;
         if (p == 3) begin
            // Halfway through, the sender stops until every read has come back.
            random_burst(PHASE_ITEMS / 2);
            drain();
            random_burst(PHASE_ITEMS - PHASE_ITEMS / 2);
         end else begin
            random_burst(PHASE_ITEMS);
         end
         drain();
         steady = 1'b0;
      end

      if (mismatch_count == 0)
         $display("mbc3_bank_controller_with_clock_regs regression: pass");
      else
         $display("mbc3_bank_controller_with_clock_regs regression: fail");
      $finish;
   end

endmodule
